// ===== design/scw_pkg.sv =====
// scw_pkg: shared types, constants and the band lookup for the scroll wheel
// acceleration block. No dependencies; every other design file uses it by
// scoped names.
package scw_pkg;

  localparam int TIME_BITS  = 32;
  localparam int BAND_COUNT = 6;

  localparam int CLICK_W  = 8;
  localparam int TICK_W   = 20;
  localparam int LIMIT_W  = 32;
  localparam int STEP_W   = 16;
  localparam int PROD_W   = CLICK_W + TICK_W;   // clicks * tick_rate
  localparam int SCALED_W = PROD_W + 3;         // rate in eighths
  localparam int SMOOTH_W = SCALED_W - 2;       // rounded rate, 29 bits
  localparam int DIV_N_W  = SCALED_W + 2;       // 2*scaled + 8*rate
  localparam int FACTOR_W = 5;
  localparam int CSTEP_W  = CLICK_W + FACTOR_W;
  localparam int DIV_STEPS = DIV_N_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int SMOOTH_DIVISOR = 3;

  // Config register map
  localparam logic [1:0] REG_IDLE_LIMIT   = 2'd0;
  localparam logic [1:0] REG_TICK_RATE    = 2'd1;
  localparam logic [1:0] REG_STEP_CEILING = 2'd2;

  localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST   = 32'd500;
  localparam logic [TICK_W-1:0]  TICK_RATE_RST    = 20'd1000;
  localparam logic [STEP_W-1:0]  STEP_CEILING_RST = 16'd1000;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] idle_limit;
    logic [TICK_W-1:0]  tick_rate;
    logic [STEP_W-1:0]  step_ceiling;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    time_t              divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

  // Bands, fastest first
  localparam logic [SMOOTH_W-1:0] BAND_FLOOR [BAND_COUNT] = '{
    29'd40, 29'd32, 29'd26, 29'd18, 29'd10, 29'd0
  };
  localparam logic [FACTOR_W-1:0] BAND_FACTOR [BAND_COUNT] = '{
    5'd16, 5'd11, 5'd7, 5'd4, 5'd2, 5'd1
  };

  // First band whose floor the rate reaches wins
  function automatic logic [FACTOR_W-1:0] band_factor(input logic [SMOOTH_W-1:0] rate);
    logic [FACTOR_W-1:0] f;
    f = FACTOR_W'(1);
    for (int k = BAND_COUNT - 1; k >= 0; k--) begin
      if (rate >= BAND_FLOOR[k]) f = BAND_FACTOR[k];
    end
    return f;
  endfunction

endpackage

// ===== design/scroll_wheel_acceleration.sv =====
// scroll_wheel_acceleration: top level with the item sequencer, spin state
// and output register. Depends on scw_pkg, scw_regs and scw_div.
//
// Usage: wheel items enter on the input channel (in_valid_i / in_stall_o)
// and exactly one scroll step per item leaves on the output channel
// (out_valid_o / out_stall_i). A transfer happens on a clock edge with valid
// high and stall low. Registers are written over the APB-style port while
// the block is idle: a rule for the user, which the block does not enforce.
// One item is in work at a time; in_stall_o is high from the transfer until
// the result is loaded into the output register. The states an item runs
// through up to that load: a clear item or pass-through, DECIDE and EMIT;
// a new spin, DECIDE, CHECK, BAND and EMIT; a continuing spin, DECIDE,
// CHECK, RATE, SMOOTH, ROUND, BAND and EMIT.
// A continuing spin runs the shared divider twice, 33 steps per pass (rate
// = clicks * tick_rate / gap, then the divide by three of the smoother).
// A result waiting under out_stall_i holds in the output register while the
// next item is taken; a finished item whose result cannot be loaded waits.
// Reset (rst_ni low, asynchronous) clears the spin state, restores the
// register defaults and empties the output register.
module scroll_wheel_acceleration (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic signed [1:0]            turn_direction_i,
  input  logic [scw_pkg::CLICK_W-1:0]  click_count_i,
  input  logic [31:0]                  event_time_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [scw_pkg::STEP_W-1:0]   scroll_step_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_CHECK, ST_RATE, ST_SMOOTH, ST_ROUND, ST_BAND, ST_EMIT
  } state_e;

  scw_pkg::cfg_t     cfg;
  scw_pkg::div_req_t div_req;
  scw_pkg::div_rsp_t div_rsp;

  state_e                          state_q;
  logic                            kind_q;
  logic                            dir_zero_q;
  logic                            neg_q;
  logic [scw_pkg::CLICK_W-1:0]     clicks_q;
  scw_pkg::time_t                  now_q;
  scw_pkg::time_t                  gap_q;
  logic                            late_q;
  logic [scw_pkg::PROD_W-1:0]      prod_q;
  logic                            spin_valid_q;
  logic                            spin_sign_q;
  scw_pkg::time_t                  prev_time_q;
  logic [scw_pkg::SCALED_W-1:0]    scaled_q;
  logic [scw_pkg::SMOOTH_W-1:0]    smoothed_q;
  logic [scw_pkg::STEP_W-1:0]      result_q;
  logic                            out_valid_q;
  logic [scw_pkg::STEP_W-1:0]      out_step_q;

  logic [scw_pkg::STEP_W-1:0]      ceiling;
  logic [scw_pkg::TIME_BITS:0]     time_diff;
  logic                            new_spin;
  logic [scw_pkg::PROD_W-1:0]      rate;
  logic [scw_pkg::DIV_N_W-1:0]     blend;
  logic [scw_pkg::CSTEP_W-1:0]     raw_step;
  logic [scw_pkg::STEP_W-1:0]      band_step;
  logic [scw_pkg::STEP_W-1:0]      pass_step;
  logic                            out_free;

  scw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  scw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign ceiling   = (cfg.step_ceiling == '0) ? scw_pkg::STEP_W'(1) : cfg.step_ceiling;
  assign pass_step = (scw_pkg::STEP_W'(clicks_q) < ceiling) ? scw_pkg::STEP_W'(clicks_q)
                                                             : ceiling;
  assign time_diff = {1'b0, now_q} - {1'b0, prev_time_q};
  assign new_spin  = !spin_valid_q || (spin_sign_q != neg_q) || late_q ||
                     (64'(gap_q) > 64'(cfg.idle_limit));
  assign rate      = div_rsp.quotient[scw_pkg::PROD_W-1:0];
  assign blend     = scw_pkg::DIV_N_W'({scaled_q, 1'b0}) +
                     scw_pkg::DIV_N_W'({rate, 3'b000});
  assign raw_step  = scw_pkg::CSTEP_W'(clicks_q) *
                     scw_pkg::CSTEP_W'(scw_pkg::band_factor(smoothed_q));
  assign band_step = (scw_pkg::STEP_W'(raw_step) > ceiling) ? ceiling
                                                            : scw_pkg::STEP_W'(raw_step);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Divider requests: rate pass from CHECK, smoothing pass when rate is done
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = scw_pkg::DIV_N_W'(prod_q);
    div_req.divisor  = (gap_q == '0) ? scw_pkg::time_t'(1) : gap_q;
    case (state_q)
      ST_CHECK: div_req.start = !new_spin;
      ST_RATE: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = blend;
        div_req.divisor  = scw_pkg::time_t'(scw_pkg::SMOOTH_DIVISOR);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= 1'b0;
      dir_zero_q   <= 1'b0;
      neg_q        <= 1'b0;
      clicks_q     <= '0;
      now_q        <= '0;
      gap_q        <= '0;
      late_q       <= 1'b0;
      prod_q       <= '0;
      spin_valid_q <= 1'b0;
      spin_sign_q  <= 1'b0;
      prev_time_q  <= '0;
      scaled_q     <= '0;
      smoothed_q   <= '0;
      result_q     <= '0;
      out_valid_q  <= 1'b0;
      out_step_q   <= '0;
    end else begin
      // Output register: load a finished result, else drop a taken one
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
        out_step_q  <= result_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            kind_q     <= kind_i;
            dir_zero_q <= (turn_direction_i == 2'sd0);
            neg_q      <= turn_direction_i[1];
            clicks_q   <= (click_count_i == '0) ? scw_pkg::CLICK_W'(1) : click_count_i;
            now_q      <= scw_pkg::time_t'(event_time_i);
            state_q    <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (kind_q) begin
            spin_valid_q <= 1'b0;
            spin_sign_q  <= 1'b0;
            prev_time_q  <= '0;
            scaled_q     <= '0;
            smoothed_q   <= '0;
            result_q     <= '0;
            state_q      <= ST_EMIT;
          end else if (dir_zero_q || cfg.tick_rate == '0) begin
            result_q <= pass_step;
            state_q  <= ST_EMIT;
          end else begin
            gap_q   <= time_diff[scw_pkg::TIME_BITS-1:0];
            late_q  <= time_diff[scw_pkg::TIME_BITS];
            prod_q  <= scw_pkg::PROD_W'(clicks_q) * scw_pkg::PROD_W'(cfg.tick_rate);
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          prev_time_q <= now_q;
          if (new_spin) begin
            scaled_q     <= '0;
            smoothed_q   <= '0;
            spin_sign_q  <= neg_q;
            spin_valid_q <= 1'b1;
            state_q      <= ST_BAND;
          end else begin
            state_q <= ST_RATE;
          end
        end
        ST_RATE: begin
          if (div_rsp.done) state_q <= ST_SMOOTH;
        end
        ST_SMOOTH: begin
          if (div_rsp.done) begin
            scaled_q <= div_rsp.quotient[scw_pkg::SCALED_W-1:0];
            state_q  <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          smoothed_q <= scw_pkg::SMOOTH_W'((scaled_q + scw_pkg::SCALED_W'(4)) >> 3);
          state_q    <= ST_BAND;
        end
        ST_BAND: begin
          result_q <= band_step;
          state_q  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign scroll_step_o = out_step_q;

endmodule

// ===== design/scw_regs.sv =====
// scw_regs: APB-style configuration registers (idle limit, tick rate, step
// ceiling). Depends on scw_pkg.
module scw_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output scw_pkg::cfg_t      cfg_o
);

  scw_pkg::cfg_t cfg_q;
  logic [1:0]    reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_limit   <= scw_pkg::IDLE_LIMIT_RST;
      cfg_q.tick_rate    <= scw_pkg::TICK_RATE_RST;
      cfg_q.step_ceiling <= scw_pkg::STEP_CEILING_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        scw_pkg::REG_IDLE_LIMIT:   cfg_q.idle_limit   <= pwdata;
        scw_pkg::REG_TICK_RATE:    cfg_q.tick_rate    <= pwdata[scw_pkg::TICK_W-1:0];
        scw_pkg::REG_STEP_CEILING: cfg_q.step_ceiling <= pwdata[scw_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      scw_pkg::REG_IDLE_LIMIT:   prdata = cfg_q.idle_limit;
      scw_pkg::REG_TICK_RATE:    prdata = 32'(cfg_q.tick_rate);
      scw_pkg::REG_STEP_CEILING: prdata = 32'(cfg_q.step_ceiling);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== design/scw_div.sv =====
// scw_div: shared restoring divider, one quotient bit per cycle. Used for
// both the spin rate and the divide-by-three smoothing. Depends on scw_pkg.
module scw_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scw_pkg::div_req_t   req_i,
  output scw_pkg::div_rsp_t   rsp_o
);

  logic [scw_pkg::DIV_N_W-1:0]   num_q;
  scw_pkg::time_t                den_q;
  scw_pkg::time_t                rem_q;
  logic [scw_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q;
  logic                          done_q;

  logic [scw_pkg::TIME_BITS:0]   shifted;
  logic [scw_pkg::TIME_BITS:0]   diff;
  logic                          fit;

  assign shifted = {rem_q, num_q[scw_pkg::DIV_N_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fit     = shifted >= {1'b0, den_q};

  // Quotient bits shift in behind the dividend bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        num_q  <= req_i.dividend;
        den_q  <= req_i.divisor;
        rem_q  <= '0;
        cnt_q  <= scw_pkg::DIV_CNT_W'(scw_pkg::DIV_STEPS);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fit ? diff[scw_pkg::TIME_BITS-1:0] : shifted[scw_pkg::TIME_BITS-1:0];
        num_q <= {num_q[scw_pkg::DIV_N_W-2:0], fit};
        cnt_q <= cnt_q - scw_pkg::DIV_CNT_W'(1);
        if (cnt_q == scw_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = num_q;

endmodule

// ===== design/scw_chk.sv =====
// scw_chk: port-level checker for scroll_wheel_acceleration, attached by
// the bind below. Depends on scw_pkg and the top level's ports.
module scw_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        kind_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [scw_pkg::STEP_W-1:0]  scroll_step_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(scroll_step_o))
    else $error("result changed under stall");

  // One item in work at a time
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transfer");

  // A new result only comes from an item in work
  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item");

  // A clear taken while the output is empty is acknowledged with a zero step
  a_clear_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && kind_i && !out_valid_o
      |-> ##3 (out_valid_o && scroll_step_o == '0))
    else $error("clear not acknowledged");

endmodule

bind scroll_wheel_acceleration scw_chk u_scw_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .kind_i        (kind_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .scroll_step_o (scroll_step_o)
);

// ===== tb/sv/scw_tb_pkg.sv =====
// scw_tb_pkg: item kinds, direction codes and register addresses shared by
// the scroll wheel acceleration testbench files. No dependencies.
`timescale 1ns / 100ps
package scw_tb_pkg;

  localparam logic ITEM_WHEEL = 1'b0;
  localparam logic ITEM_CLEAR = 1'b1;

  localparam logic [1:0] DIR_NONE      = 2'b00;
  localparam logic [1:0] DIR_UP        = 2'b01;
  localparam logic [1:0] DIR_DOWN      = 2'b11;
  localparam logic [1:0] DIR_DOWN_WIDE = 2'b10;  // -2, still a downward turn

  // Byte addresses on the register port, 4 per register
  localparam logic [3:0] ADDR_IDLE_LIMIT   = 4'h0;
  localparam logic [3:0] ADDR_TICK_RATE    = 4'h4;
  localparam logic [3:0] ADDR_STEP_CEILING = 4'h8;
  localparam logic [3:0] ADDR_SPARE        = 4'hC;  // no register here

endpackage

// ===== tb/sv/scw_step_monitor.sv =====
// scw_step_monitor: watches the register port and both item channels of the
// scroll wheel acceleration block, predicts every step and compares it.
// Depends on scw_pkg for port widths and on scw_tb_pkg for codes.
`timescale 1ns / 100ps
module scw_step_monitor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        kind_i,
  input  logic [1:0]                  turn_direction_i,
  input  logic [scw_pkg::CLICK_W-1:0] click_count_i,
  input  logic [31:0]                 event_time_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [scw_pkg::STEP_W-1:0]  scroll_step_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o
);

  // register copies
  logic [31:0] idle_limit_q   = 32'd500;
  logic [19:0] tick_rate_q    = 20'd1000;
  logic [15:0] step_ceiling_q = 16'd1000;

  // spin state
  logic        spin_on        = 1'b0;
  logic        spin_neg       = 1'b0;
  logic [31:0] spin_last_time = '0;
  logic [31:0] rate_eighths   = '0;
  logic [28:0] rate_smooth    = '0;

  logic [15:0] expected_steps [$];
  logic [15:0] want_step;
  int          mismatches = 0;
  int          pending_q  = 0;
  int          checked_q  = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_q;
  assign checked_o    = checked_q;

  task automatic report_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void clear_spin();
    spin_on        = 1'b0;
    spin_neg       = 1'b0;
    spin_last_time = '0;
    rate_eighths   = '0;
    rate_smooth    = '0;
  endfunction

  // fastest band first
  function automatic int unsigned band_multiplier(input logic [28:0] rate);
    if (rate >= 29'd40) return 16;
    if (rate >= 29'd32) return 11;
    if (rate >= 29'd26) return 7;
    if (rate >= 29'd18) return 4;
    if (rate >= 29'd10) return 2;
    return 1;
  endfunction

  function automatic logic [15:0] predict_scroll_step(input logic kind,
      input logic [1:0] dir, input logic [7:0] clicks_in, input logic [31:0] now);
    int unsigned ceiling;
    int unsigned clicks;
    int unsigned step;
    logic [63:0] gap;
    logic [63:0] rate;
    logic        neg;
    ceiling = (step_ceiling_q == 16'd0) ? 1 : step_ceiling_q;
    if (kind == scw_tb_pkg::ITEM_CLEAR) begin
      clear_spin();
      return 16'd0;
    end
    clicks = (clicks_in == 8'd0) ? 1 : clicks_in;
    if (dir == scw_tb_pkg::DIR_NONE || tick_rate_q == 20'd0)
      return 16'((clicks < ceiling) ? clicks : ceiling);
    neg = dir[1];
    if (!spin_on || spin_neg != neg || now < spin_last_time ||
        64'(now - spin_last_time) > 64'(idle_limit_q)) begin
      // restart the spin at rate zero
      rate_eighths = '0;
      rate_smooth  = '0;
      spin_neg     = neg;
      spin_on      = 1'b1;
    end else begin
      gap = 64'(now - spin_last_time);
      if (gap == 64'd0) gap = 64'd1;
      rate = (64'(clicks) * 64'(tick_rate_q)) / gap;
      rate_eighths = 32'((64'(rate_eighths) * 2 + rate * 8) / 3);
      rate_smooth  = 29'((64'(rate_eighths) + 4) / 8);
    end
    spin_last_time = now;
    step = clicks * band_multiplier(rate_smooth);
    if (step < 1) step = 1;
    if (step > ceiling) step = ceiling;
    return 16'(step);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_limit_q   = 32'd500;
      tick_rate_q    = 20'd1000;
      step_ceiling_q = 16'd1000;
      clear_spin();
      expected_steps.delete();
      pending_q <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          scw_tb_pkg::ADDR_IDLE_LIMIT:   idle_limit_q   = pwdata;
          scw_tb_pkg::ADDR_TICK_RATE:    tick_rate_q    = pwdata[19:0];
          scw_tb_pkg::ADDR_STEP_CEILING: step_ceiling_q = pwdata[15:0];
          default: ;
        endcase
      end
      // a result never leaves on the edge that takes its item, so pop first
      if (out_valid_i && !out_stall_i) begin
        if (expected_steps.size() == 0) begin
          report_mismatch($sformatf("step %0d with no item pending", scroll_step_i));
        end else begin
          want_step = expected_steps.pop_front();
          if (scroll_step_i !== want_step)
            report_mismatch($sformatf("scroll_step %0d, predicted %0d",
                                      scroll_step_i, want_step));
          checked_q <= checked_q + 1;
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_steps.push_back(predict_scroll_step(kind_i, turn_direction_i,
                                                     click_count_i, event_time_i));
      pending_q <= expected_steps.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: stimulus and verdict for scroll_wheel_acceleration. Directed spins,
// then random spins under several register settings with random pacing.
// Depends on scw_pkg, scw_tb_pkg, scw_step_monitor and the block itself.
`timescale 1ns / 100ps
module tb_top;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int SETTLE_CYCLES = 80;

  logic        clk_i;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic                        in_valid_i       = 1'b0;
  logic                        in_stall_o;
  logic                        kind_i           = scw_tb_pkg::ITEM_WHEEL;
  logic [1:0]                  turn_direction_i = scw_tb_pkg::DIR_NONE;
  logic [scw_pkg::CLICK_W-1:0] click_count_i    = '0;
  logic [31:0]                 event_time_i     = '0;
  logic                        out_valid_o;
  logic                        out_stall_i      = 1'b0;
  logic [scw_pkg::STEP_W-1:0]  scroll_step_o;

  int          fail_count;
  int          pending;
  int          steps_checked;
  int          items_sent     = 0;
  int          settings_count = 0;
  int          cycle_count    = 0;
  int          steps_taken    = 0;
  int          stall_left     = 0;
  logic        tx_quiet       = 1'b0;
  logic        rx_quiet       = 1'b0;
  logic [31:0] idle_now       = 32'd500;

  scroll_wheel_acceleration dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .turn_direction_i (turn_direction_i),
    .click_count_i    (click_count_i),
    .event_time_i     (event_time_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .scroll_step_o    (scroll_step_o)
  );

  scw_step_monitor mon (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .kind_i           (kind_i),
    .turn_direction_i (turn_direction_i),
    .click_count_i    (click_count_i),
    .event_time_i     (event_time_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .scroll_step_i    (scroll_step_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (steps_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver: a random stall after each taken result, with quiet stretches
  always @(posedge clk_i) begin : rx_pace
    int unsigned hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      steps_taken <= steps_taken + 1;
      if (steps_taken % 40 == 0) rx_quiet <= ($urandom_range(0, 2) == 0);
      hold = rx_quiet ? 0 : $urandom_range(0, 15);
      stall_left  <= hold;
      out_stall_i <= (hold != 0);
    end else if (out_valid_o && stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // valid stays high across back-to-back items; callers lower it before idling
  task automatic send_item(input logic kind, input logic [1:0] dir,
                           input logic [7:0] clicks, input logic [31:0] stamp);
    int unsigned gap_cycles;
    gap_cycles = tx_quiet ? 0 : $urandom_range(0, 15);
    if (gap_cycles != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_cycles) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    kind_i           <= kind;
    turn_direction_i <= dir;
    click_count_i    <= clicks;
    event_time_i     <= stamp;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic drain_steps();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic apply_settings(input logic [31:0] idle, input logic [31:0] ticks,
                                input logic [31:0] ceiling);
    drain_steps();
    reg_write(scw_tb_pkg::ADDR_IDLE_LIMIT, idle);
    reg_write(scw_tb_pkg::ADDR_TICK_RATE, ticks);
    reg_write(scw_tb_pkg::ADDR_STEP_CEILING, ceiling);
    idle_now = idle;
    settings_count++;
  endtask

  // Mostly well-formed spins with random clicks and gaps; the rest restarts,
  // reversals, backward time, long idles, clears and pass-through noise.
  task automatic run_spins(input int count);
    logic [31:0] spin_time;
    logic [1:0]  spin_dir;
    logic [1:0]  dir;
    logic [7:0]  clicks;
    logic [63:0] gap;
    int unsigned pick;
    int unsigned reach;
    spin_time = $urandom;
    spin_dir  = scw_tb_pkg::DIR_UP;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 39) == 0) drain_steps();
      pick   = $urandom_range(0, 99);
      clicks = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 6));
      if (pick < 3) begin
        send_item(scw_tb_pkg::ITEM_CLEAR, 2'($urandom), 8'($urandom), $urandom);
        continue;
      end
      if (pick < 9) begin
        send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_NONE, clicks, $urandom);
        continue;
      end
      if (pick < 16) begin
        // fresh spin, sometimes just short of the timestamp wrap
        spin_dir  = ($urandom_range(0, 1) == 0) ? scw_tb_pkg::DIR_UP
                                                : scw_tb_pkg::DIR_DOWN;
        spin_time = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4000)
                                                : $urandom;
      end else if (pick < 20) begin
        spin_time = spin_time - $urandom_range(1, 100);
      end else if (pick < 24) begin
        spin_time = spin_time + idle_now + $urandom_range(1, 1000);
      end else begin
        reach = $urandom_range(0, 9);
        if (reach < 6)      gap = $urandom_range(0, 40);
        else if (reach < 9) gap = $urandom_range(0, 400);
        else                gap = $urandom_range(0, idle_now);
        if (gap > 64'(idle_now)) gap = 64'(idle_now);
        spin_time = spin_time + 32'(gap);
      end
      dir = spin_dir;
      if (spin_dir != scw_tb_pkg::DIR_UP && $urandom_range(0, 1) == 0)
        dir = scw_tb_pkg::DIR_DOWN_WIDE;
      send_item(scw_tb_pkg::ITEM_WHEEL, dir, clicks, spin_time);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings: idle 500, 1000 ticks/s, ceiling 1000
    tx_quiet = 1'b1;
    send_item(scw_tb_pkg::ITEM_CLEAR, scw_tb_pkg::DIR_UP, 8'd255, 32'hFFFF_FFFF);
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_NONE, 8'd0, 32'd0);
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_NONE, 8'd255, 32'd12345);
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_UP, 8'd3, 32'd100);
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_UP, 8'd1, 32'd110);
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_UP, 8'd1, 32'd110);   // same tick
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_UP, 8'd255, 32'd115); // clamps
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_DOWN, 8'd2, 32'd120); // reversal
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_DOWN_WIDE, 8'd2, 32'd130);
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_DOWN, 8'd1, 32'd40);  // time back
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_DOWN, 8'd1, 32'd540); // gap at limit
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_DOWN, 8'd1, 32'd1041); // one past
    send_item(scw_tb_pkg::ITEM_CLEAR, scw_tb_pkg::DIR_NONE, 8'd0, 32'd0);
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_DOWN, 8'd1, 32'd1045);
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_UP, 8'd1, 32'hFFFF_FFF0);
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_UP, 8'd1, 32'hFFFF_FFFF);
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_UP, 8'd1, 32'd0);     // wrapped

    // zero tick rate and zero ceiling: plain pass-through clamped to one
    apply_settings(32'd500, 32'd0, 32'd0);
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_UP, 8'd7, 32'd5);
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_DOWN, 8'd0, 32'd6);

    // widest product: full clicks at full tick rate over a one-tick gap
    apply_settings(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_UP, 8'd255, 32'd1000);
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_UP, 8'd255, 32'd1000);
    send_item(scw_tb_pkg::ITEM_WHEEL, scw_tb_pkg::DIR_UP, 8'd255, 32'd1001);

    apply_settings(32'd500, 32'd1000, 32'd1000);
    reg_write(scw_tb_pkg::ADDR_SPARE, $urandom);         // must change nothing
    run_spins(130);
    apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF);
    run_spins(130);
    apply_settings(32'd0, 32'd1000, 32'd0);
    run_spins(130);
    apply_settings(32'd200, 32'd0, 32'd50);
    run_spins(80);
    apply_settings(32'd300, 32'd1, 32'd1);
    run_spins(130);
    apply_settings($urandom_range(1, 2000), $urandom_range(100, 5000),
                   $urandom_range(1, 16'hFFFF));
    run_spins(130);

    drain_steps();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d wheel and clear items under %0d register settings.",
             items_sent, settings_count + 1);
    $display("%0d scroll steps compared against the prediction.", steps_checked);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d steps still pending.", cycle_count, pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/scw_pkg.sv
design/scw_regs.sv
design/scw_div.sv
design/scroll_wheel_acceleration.sv
design/scw_chk.sv
tb/sv/scw_tb_pkg.sv
tb/sv/scw_step_monitor.sv
tb/sv/tb_top.sv
